// File: hw/rtl/balu_pkg.sv
// Shared item types, operation codes and status bit positions for the byte ALU.
`default_nettype none

package balu_pkg;

  localparam int unsigned OpWidth   = 5;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned BitIdxW   = 3;

  // Operation codes
  localparam logic [OpWidth-1:0] OP_LOAD   = 5'd0;
  localparam logic [OpWidth-1:0] OP_ADC    = 5'd1;
  localparam logic [OpWidth-1:0] OP_SBC    = 5'd2;
  localparam logic [OpWidth-1:0] OP_CMP    = 5'd3;
  localparam logic [OpWidth-1:0] OP_AND    = 5'd4;
  localparam logic [OpWidth-1:0] OP_OR     = 5'd5;
  localparam logic [OpWidth-1:0] OP_XOR    = 5'd6;
  localparam logic [OpWidth-1:0] OP_BIT    = 5'd7;
  localparam logic [OpWidth-1:0] OP_BITIMM = 5'd8;
  localparam logic [OpWidth-1:0] OP_TSB    = 5'd9;
  localparam logic [OpWidth-1:0] OP_TRB    = 5'd10;
  localparam logic [OpWidth-1:0] OP_ASL    = 5'd11;
  localparam logic [OpWidth-1:0] OP_ROL    = 5'd12;
  localparam logic [OpWidth-1:0] OP_LSR    = 5'd13;
  localparam logic [OpWidth-1:0] OP_ROR    = 5'd14;
  localparam logic [OpWidth-1:0] OP_INC    = 5'd15;
  localparam logic [OpWidth-1:0] OP_DEC    = 5'd16;
  localparam logic [OpWidth-1:0] OP_CLC    = 5'd17;
  localparam logic [OpWidth-1:0] OP_SEC    = 5'd18;
  localparam logic [OpWidth-1:0] OP_CLD    = 5'd19;
  localparam logic [OpWidth-1:0] OP_SED    = 5'd20;
  localparam logic [OpWidth-1:0] OP_CLV    = 5'd21;
  localparam logic [OpWidth-1:0] OP_RMB    = 5'd22;
  localparam logic [OpWidth-1:0] OP_SMB    = 5'd23;

  // Status byte bit positions: N V 1 B D I Z C
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  typedef struct packed {
    logic [OpWidth-1:0]   operation;
    logic [ByteWidth-1:0] reg_value;
    logic [ByteWidth-1:0] mem_value;
    logic [BitIdxW-1:0]   bit_index;
    logic [ByteWidth-1:0] flags_in;
  } req_item_t;

  typedef struct packed {
    logic [ByteWidth-1:0] result;
    logic [ByteWidth-1:0] flags_out;
  } rsp_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/byte_alu_with_status_flags_core.sv
// Eight-bit ALU with status byte update; three register stages, one item per cycle while req_stall is low.
// Three-stage pipeline: stage 1 registers the item and sets up the adder operands,
// stage 2 runs the 9-bit adder, the logic unit and the shifter, stage 3 builds the
// new status byte and holds the finished item. An accepted item passes through the
// stage 1, stage 2 and stage 3 registers before rsp_valid rises; one item can be
// accepted every cycle while req_stall is low. A stall on the result side
// holds the last stage; earlier stages keep filling bubbles, and req_stall rises
// only when all three stages are full and the result is not taken.
// Decimal mode is not implemented: D is only stored.
`default_nettype none

module byte_alu_with_status_flags_core
  import balu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire req_item_t req_data,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output rsp_item_t      rsp_data
);

  typedef struct packed {
    logic [OpWidth-1:0]   op;
    logic [ByteWidth-1:0] r;
    logic [ByteWidth-1:0] m;
    logic [BitIdxW-1:0]   bi;
    logic [ByteWidth-1:0] p;
    logic [ByteWidth-1:0] a;
    logic [ByteWidth-1:0] b;
    logic                 cin;
  } s1_t;

  typedef struct packed {
    logic [OpWidth-1:0]   op;
    logic [ByteWidth-1:0] res;
    logic [ByteWidth-1:0] nz_src;
    logic                 c_new;
    logic                 v_new;
    logic                 z_and;
    logic                 m7;
    logic                 m6;
    logic [ByteWidth-1:0] p;
  } s2_t;

  logic v1, v2, v3;
  logic en1, en2, en3;
  s1_t  s1, s1_next;
  s2_t  s2, s2_next;
  rsp_item_t s3_next;

  // A stage loads when it is empty or its contents move on.
  assign en3       = !v3 || !rsp_stall;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign req_stall = !en1;
  assign rsp_valid = v3;

  // Stage 1: adder operand setup
  always_comb begin
    s1_next.op  = req_data.operation;
    s1_next.r   = req_data.reg_value;
    s1_next.m   = req_data.mem_value;
    s1_next.bi  = req_data.bit_index;
    s1_next.p   = req_data.flags_in;
    s1_next.a   = req_data.reg_value;
    s1_next.b   = req_data.mem_value;
    s1_next.cin = req_data.flags_in[FLAG_C];
    unique case (req_data.operation)
      OP_SBC: begin
        s1_next.b = ~req_data.mem_value;
      end
      OP_CMP: begin
        s1_next.b   = ~req_data.mem_value;
        s1_next.cin = 1'b1;
      end
      OP_INC: begin
        s1_next.a   = req_data.mem_value;
        s1_next.b   = '0;
        s1_next.cin = 1'b1;
      end
      OP_DEC: begin
        s1_next.a   = req_data.mem_value;
        s1_next.b   = '1;
        s1_next.cin = 1'b0;
      end
      default: ;
    endcase
  end

  // Stage 2: adder, logic unit, shifter
  logic [ByteWidth:0]   sum;
  logic [ByteWidth-1:0] bit_mask;

  always_comb begin
    sum      = {1'b0, s1.a} + {1'b0, s1.b} + {{ByteWidth{1'b0}}, s1.cin};
    bit_mask = ByteWidth'(1) << s1.bi;

    s2_next.op    = s1.op;
    s2_next.p     = s1.p;
    s2_next.m7    = s1.m[ByteWidth-1];
    s2_next.m6    = s1.m[ByteWidth-2];
    s2_next.z_and = (s1.r & s1.m) == '0;
    // same overflow rule serves adc and sbc, since b is already inverted for sbc
    s2_next.v_new = (s1.a[ByteWidth-1] ^ sum[ByteWidth-1])
                  & (s1.b[ByteWidth-1] ^ sum[ByteWidth-1]);
    s2_next.c_new = sum[ByteWidth];
    s2_next.res   = s1.r;

    unique case (s1.op) inside
      OP_LOAD:                         s2_next.res = s1.m;
      OP_ADC, OP_SBC, OP_INC, OP_DEC:  s2_next.res = sum[ByteWidth-1:0];
      OP_AND:                          s2_next.res = s1.r & s1.m;
      OP_OR, OP_TSB:                   s2_next.res = s1.r | s1.m;
      OP_XOR:                          s2_next.res = s1.r ^ s1.m;
      OP_TRB:                          s2_next.res = ~s1.r & s1.m;
      OP_ASL: begin
        s2_next.res   = {s1.m[ByteWidth-2:0], 1'b0};
        s2_next.c_new = s1.m[ByteWidth-1];
      end
      OP_ROL: begin
        s2_next.res   = {s1.m[ByteWidth-2:0], s1.p[FLAG_C]};
        s2_next.c_new = s1.m[ByteWidth-1];
      end
      OP_LSR: begin
        s2_next.res   = {1'b0, s1.m[ByteWidth-1:1]};
        s2_next.c_new = s1.m[0];
      end
      OP_ROR: begin
        s2_next.res   = {s1.p[FLAG_C], s1.m[ByteWidth-1:1]};
        s2_next.c_new = s1.m[0];
      end
      OP_RMB:                          s2_next.res = s1.m & ~bit_mask;
      OP_SMB:                          s2_next.res = s1.m | bit_mask;
      default: ;
    endcase

    // compare sets N and Z from the difference but writes back nothing
    s2_next.nz_src = (s1.op == OP_CMP) ? sum[ByteWidth-1:0] : s2_next.res;
  end

  // Stage 3: status byte
  logic nz_zero;

  always_comb begin
    nz_zero           = s2.nz_src == '0;
    s3_next.result    = s2.res;
    s3_next.flags_out = s2.p;
    unique case (s2.op) inside
      OP_LOAD, OP_AND, OP_OR, OP_XOR, OP_INC, OP_DEC: begin
        s3_next.flags_out[FLAG_Z] = nz_zero;
        s3_next.flags_out[FLAG_N] = s2.nz_src[ByteWidth-1];
      end
      OP_ADC, OP_SBC: begin
        s3_next.flags_out[FLAG_C] = s2.c_new;
        s3_next.flags_out[FLAG_V] = s2.v_new;
        s3_next.flags_out[FLAG_Z] = nz_zero;
        s3_next.flags_out[FLAG_N] = s2.nz_src[ByteWidth-1];
      end
      OP_CMP, OP_ASL, OP_ROL, OP_LSR, OP_ROR: begin
        s3_next.flags_out[FLAG_C] = s2.c_new;
        s3_next.flags_out[FLAG_Z] = nz_zero;
        s3_next.flags_out[FLAG_N] = s2.nz_src[ByteWidth-1];
      end
      OP_BIT: begin
        s3_next.flags_out[FLAG_Z] = s2.z_and;
        s3_next.flags_out[FLAG_N] = s2.m7;
        s3_next.flags_out[FLAG_V] = s2.m6;
      end
      OP_BITIMM, OP_TSB, OP_TRB: s3_next.flags_out[FLAG_Z] = s2.z_and;
      OP_CLC:                    s3_next.flags_out[FLAG_C] = 1'b0;
      OP_SEC:                    s3_next.flags_out[FLAG_C] = 1'b1;
      OP_CLD:                    s3_next.flags_out[FLAG_D] = 1'b0;
      OP_SED:                    s3_next.flags_out[FLAG_D] = 1'b1;
      OP_CLV:                    s3_next.flags_out[FLAG_V] = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= req_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1       <= s1_next;
    if (en2) s2       <= s2_next;
    if (en3) rsp_data <= s3_next;
  end

  // stall back to the source only with a completely full pipe
  assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (v1 && v2 && v3 && rsp_stall))
    else $error("req_stall with a free stage");

  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> v1)
    else $error("accepted item not in stage 1");

  assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && rsp_stall) |=> (v1 && v2 && v3))
    else $error("item lost during stall");

  assert property (@(posedge clk) disable iff (rst)
    (v2 && en3 && (s2.op == OP_CLC)) |=> !rsp_data.flags_out[FLAG_C])
    else $error("clc left carry set");

  assert property (@(posedge clk) disable iff (rst)
    (v2 && en3 && (s2.op == OP_RMB || s2.op == OP_SMB)) |=>
      (rsp_data.flags_out == $past(s2.p)))
    else $error("bit reset or set changed flags");

endmodule

`default_nettype wire
